// ===== hdl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/uidh_pkg.sv =====
package uidh_pkg;

    localparam logic [3:0]  LastPos  = 4'd15;
    localparam logic [31:0] CrcPoly  = 32'hEDB88320;
    localparam logic [31:0] CrcInit  = 32'hFFFFFFFF;
    localparam logic [7:0]  PadChar  = 8'h2E;

    // where the current byte falls inside its group of three
    localparam logic [1:0] PhFirst = 2'd0;
    localparam logic [1:0] PhMid   = 2'd1;
    localparam logic [1:0] PhLast  = 2'd2;

    // characters produced by one byte, lowest index folded first
    typedef struct packed {
        logic [3:0]      en;
        logic [3:0][7:0] chars;
    } t_chars;

    // url-safe base64 alphabet
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'h2D;
        end else begin
            c = 8'h5F;
        end
        return c;
    endfunction

    // reflected crc-32 update by one byte
    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] ch);
        logic [31:0] c;
        c = crc ^ {24'd0, ch};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hdl/uidh_enc.sv =====
module uidh_enc (
    input  logic [7:0]      i_byte,
    input  logic [7:0]      i_held,
    input  logic [1:0]      i_phase,
    input  logic            i_last,
    output uidh_pkg::t_chars o_chars
);
    import uidh_pkg::*;

    always_comb begin
        o_chars = '0;
        if (i_last) begin
            o_chars.en       = 4'b1111;
            o_chars.chars[0] = b64_char(i_byte[7:2]);
            o_chars.chars[1] = b64_char({i_byte[1:0], 4'b0000});
            o_chars.chars[2] = PadChar;
            o_chars.chars[3] = PadChar;
        end else begin
            case (i_phase)
                PhFirst: begin
                    o_chars.en       = 4'b0001;
                    o_chars.chars[0] = b64_char(i_byte[7:2]);
                end
                PhMid: begin
                    o_chars.en       = 4'b0001;
                    o_chars.chars[0] = b64_char({i_held[1:0], i_byte[7:4]});
                end
                PhLast: begin
                    o_chars.en       = 4'b0011;
                    o_chars.chars[0] = b64_char({i_held[3:0], i_byte[7:6]});
                    o_chars.chars[1] = b64_char(i_byte[5:0]);
                end
                default: begin
                    o_chars = '0;
                end
            endcase
        end
    end

endmodule

// ===== hdl/uidh_crc.sv =====
module uidh_crc (
    input  logic [31:0]      i_crc,
    input  uidh_pkg::t_chars i_chars,
    output logic [31:0]      o_crc
);
    import uidh_pkg::*;

    // up to four chained byte folds
    always_comb begin
        o_crc = i_crc;
        for (int i = 0; i < 4; i++) begin
            if (i_chars.en[i]) begin
                o_crc = crc_fold(o_crc, i_chars.chars[i]);
            end
        end
    end

endmodule

// ===== hdl/user_id_base64_crc32_hash.sv =====
// channel | direction | valid      | stall       | payload
// input   | in        | i_in_valid | o_in_stall  | i_id_byte (8 bits)
// output  | out       | o_out_valid| i_out_stall | o_sampling_hash (32 bits)
//
// one byte accepted per cycle unless the input stalls; each byte passes an input
// register, then encode plus crc folding (up to four chained byte updates) into
// the state and result registers; the 16th byte's hash goes into the result register.
// reset is synchronous, active low; it empties both registers and presets the crc.
// input stalls only while a byte waits and an unaccepted hash blocks the result register.
`include "assert_macros.svh"

module user_id_base64_crc32_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic [7:0]  i_id_byte,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output logic [31:0] o_sampling_hash,
    input  logic        i_out_stall
);
    import uidh_pkg::*;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // running hash state
    logic [3:0]  r_pos;
    logic [1:0]  r_phase;
    logic [7:0]  r_held;
    logic [31:0] r_crc;

    // result register
    logic        r_out_valid;
    logic [31:0] r_out_hash;

    logic        w_out_block;
    logic        w_fire;
    logic        w_last;
    t_chars      w_chars;
    logic [31:0] n_crc;
    logic [1:0]  n_phase;

    // a held result that is not being taken blocks the compute stage
    assign w_out_block = r_out_valid & i_out_stall;
    assign w_fire      = r_in_valid & ~w_out_block;
    assign o_in_stall  = r_in_valid & w_out_block;
    assign w_last      = (r_pos == LastPos);

    // characters this byte completes
    uidh_enc u_enc (
        .i_byte  (r_in_byte),
        .i_held  (r_held),
        .i_phase (r_phase),
        .i_last  (w_last),
        .o_chars (w_chars)
    );

    // fold them into the running crc
    uidh_crc u_crc (
        .i_crc   (r_crc),
        .i_chars (w_chars),
        .o_crc   (n_crc)
    );

    // group-of-three phase advance
    always_comb begin
        case (r_phase)
            PhFirst: n_phase = PhMid;
            PhMid:   n_phase = PhLast;
            PhLast:  n_phase = PhFirst;
            default: n_phase = PhFirst;
        endcase
    end

    // input register, loads whenever not stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_id_byte;
        end
    end

    // state update; the 16th byte returns everything to the start state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 4'd0;
            r_phase <= PhFirst;
            r_held  <= 8'd0;
            r_crc   <= CrcInit;
        end else if (w_fire) begin
            if (w_last) begin
                r_pos   <= 4'd0;
                r_phase <= PhFirst;
                r_held  <= 8'd0;
                r_crc   <= CrcInit;
            end else begin
                r_pos   <= r_pos + 4'd1;
                r_phase <= n_phase;
                r_held  <= r_in_byte;
                r_crc   <= n_crc;
            end
        end
    end

    // result register with final complement
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_last) begin
            r_out_hash <= ~n_crc;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sampling_hash = r_out_hash;

    // start of an identifier always sees a preset crc and a fresh group
    `ASSERT_IMPLY(a_start_state, i_clk, i_rst_n, r_pos == 4'd0, (r_crc == CrcInit) && (r_phase == PhFirst))
    // the last byte always produces a hash in the next cycle
    `ASSERT_NEXT(a_last_gives_hash, i_clk, i_rst_n, w_fire && w_last, o_out_valid)
    // a hash only ever appears from a last byte
    `ASSERT_IMPLY(a_hash_source, i_clk, i_rst_n, $rose(o_out_valid), $past(w_fire && w_last))
    // input is never held off while the result register is empty
    `ASSERT_ALWAYS(a_no_idle_stall, i_clk, i_rst_n, r_out_valid || !o_in_stall)

endmodule
